@@ rtl/core/cross_window_byte_and_core_defines.svh @@
// Assertion macros shared by the cross window AND core.
`ifndef CROSS_WINDOW_BYTE_AND_CORE_DEFINES_SVH
`define CROSS_WINDOW_BYTE_AND_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CWBA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CWBA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/cwba_pkg.sv @@
// Types and constants shared by the cross window AND core.
`timescale 1ns / 1ps

package cwba_pkg;

   localparam int PIX_W      = 8;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 10;
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam int RAD_W      = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS       = 2'd2;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int RESET_RADIUS = 1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic             emit;
      logic             interior;
      logic             done;
      logic [RAD_W-1:0] rad;
   } cwba_flags_type;

   typedef struct packed {
      logic             done;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic [PIX_W-1:0] value;
   } cwba_rsp_type;

endpackage

@@ rtl/core/cwba_store.sv @@
// Column-major row store: one word per column holds one byte per stored row.
`timescale 1ns / 1ps

module cwba_store #(
   parameter int DEPTH  = 1024,
   parameter int WORD_W = 48
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd1_addr,
   input  logic [$clog2(DEPTH)-1:0] rd2_addr,
   output logic [WORD_W-1:0]        rd1_data,
   output logic [WORD_W-1:0]        rd2_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_W-1:0]        wr_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd1_data_ff;
   logic [WORD_W-1:0] rd2_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd1_data_ff <= mem[rd1_addr];
         rd2_data_ff <= mem[rd2_addr];
      end
   end

   assign rd1_data = rd1_data_ff;
   assign rd2_data = rd2_data_ff;

endmodule

@@ rtl/core/cwba_pos.sv @@
// Settings registers, raster position tracking and store read issue.
`timescale 1ns / 1ps

module cwba_pos #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_RADIUS = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cwba_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [cwba_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                acc,
   input  logic [cwba_pkg::PIX_W-1:0]          pixel,
   input  logic                                frame_start,
   output logic [$clog2(MAX_WIDTH)-1:0]        rd1_addr,
   output logic [$clog2(MAX_WIDTH)-1:0]        rd2_addr,
   output logic                                s1_valid,
   output logic [cwba_pkg::PIX_W-1:0]          s1_pix,
   output logic [$clog2(MAX_WIDTH)-1:0]        s1_x,
   output logic [$clog2(2*MAX_RADIUS)-1:0]     s1_slot_y,
   output logic [$clog2(2*MAX_RADIUS)-1:0]     s1_slot_c,
   output logic [cwba_pkg::ROW_W-1:0]          s1_row,
   output logic [cwba_pkg::COL_W-1:0]          s1_col,
   output cwba_pkg::cwba_flags_type            s1_flags
);
   import cwba_pkg::*;

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int NSLOT = 2 * MAX_RADIUS;
   localparam int SW    = $clog2(NSLOT);

   localparam logic [WW-1:0] W_RESET =
      WW'((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH);
   localparam logic [HW-1:0] H_RESET =
      HW'((RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT);
   localparam logic [RAD_W-1:0] R_RESET =
      RAD_W'((RESET_RADIUS > MAX_RADIUS) ? MAX_RADIUS : RESET_RADIUS);

   logic [WW-1:0]    w_ff;
   logic [HW-1:0]    h_ff;
   logic [RAD_W-1:0] r_ff;
   logic [XW-1:0]    x_ff, x_in, cur_x;
   logic [YW-1:0]    y_ff, y_in, cur_y, cur_c;
   logic [SW-1:0]    slot_ff, slot_in, cur_slot, cur_slot_c;

   logic [FW_W-1:0]  fw;
   logic [FH_W-1:0]  fh;
   logic [RAD_W-1:0] fr;
   logic [WW-1:0]    w_clamp;
   logic [HW-1:0]    h_clamp;
   logic [RAD_W-1:0] r_clamp;

   logic [WW-1:0]    x_inc;
   logic [HW-1:0]    y_inc;
   logic             row_restart;

   logic                 s1_valid_ff;
   logic [PIX_W-1:0]     s1_pix_ff;
   logic [XW-1:0]        s1_x_ff;
   logic [SW-1:0]        s1_slot_y_ff, s1_slot_c_ff;
   logic [ROW_W-1:0]     s1_row_ff;
   logic [COL_W-1:0]     s1_col_ff;
   cwba_flags_type       s1_flags_ff, flags;

   // clamp register values on the way in
   always_comb begin
      fw = csr_wdata[FW_W-1:0];
      fh = csr_wdata[FH_W-1:0];
      fr = csr_wdata[RAD_W-1:0];
      if (fw == '0) begin
         w_clamp = WW'(1);
      end else if (32'(fw) > MAX_WIDTH) begin
         w_clamp = WW'(MAX_WIDTH);
      end else begin
         w_clamp = WW'(fw);
      end
      if (fh == '0) begin
         h_clamp = HW'(1);
      end else if (32'(fh) > MAX_HEIGHT) begin
         h_clamp = HW'(MAX_HEIGHT);
      end else begin
         h_clamp = HW'(fh);
      end
      if (32'(fr) > MAX_RADIUS) begin
         r_clamp = RAD_W'(MAX_RADIUS);
      end else begin
         r_clamp = fr;
      end
   end

   // position of the arriving pixel and the one after it
   always_comb begin
      row_restart = frame_start || (32'(y_ff) >= 32'(h_ff));
      cur_y    = row_restart ? '0 : y_ff;
      cur_slot = row_restart ? '0 : slot_ff;
      cur_x    = (frame_start || (32'(x_ff) >= 32'(w_ff))) ? '0 : x_ff;

      x_inc   = WW'(cur_x) + WW'(1);
      y_inc   = HW'(cur_y) + HW'(1);
      x_in    = XW'(x_inc);
      y_in    = cur_y;
      slot_in = cur_slot;
      if (x_inc >= w_ff) begin
         x_in = '0;
         if (y_inc >= h_ff) begin
            y_in    = '0;
            slot_in = '0;
         end else begin
            y_in    = YW'(y_inc);
            slot_in = (32'(cur_slot) == NSLOT - 1) ? '0 : cur_slot + SW'(1);
         end
      end

      cur_c = cur_y - YW'(r_ff);
      if (32'(cur_slot) >= 32'(r_ff)) begin
         cur_slot_c = cur_slot - SW'(r_ff);
      end else begin
         cur_slot_c = SW'((SW+3)'(cur_slot) + (SW+3)'(NSLOT) - (SW+3)'(r_ff));
      end

      flags.rad      = r_ff;
      flags.emit     = 32'(cur_y) >= 32'(r_ff);
      flags.interior = (32'(cur_y) >= 32'({r_ff, 1'b0})) &&
                       (32'(cur_x) >= 32'(r_ff)) &&
                       ((32'(cur_x) + 32'(r_ff)) < 32'(w_ff));
      flags.done     = (HW'(cur_y) == h_ff - HW'(1)) && (WW'(cur_x) == w_ff - WW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff        <= W_RESET;
         h_ff        <= H_RESET;
         r_ff        <= R_RESET;
         x_ff        <= '0;
         y_ff        <= '0;
         slot_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= acc;
         if (csr_we) begin
            case (csr_addr)
               CSR_FRAME_WIDTH: begin
                  w_ff <= w_clamp;
               end
               CSR_FRAME_HEIGHT: begin
                  h_ff <= h_clamp;
               end
               CSR_RADIUS: begin
                  r_ff <= r_clamp;
               end
               default: begin
               end
            endcase
            // any write sends the position back to the frame origin
            x_ff    <= '0;
            y_ff    <= '0;
            slot_ff <= '0;
         end else if (acc) begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            slot_ff <= slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pix_ff    <= pixel;
         s1_x_ff      <= cur_x;
         s1_slot_y_ff <= cur_slot;
         s1_slot_c_ff <= cur_slot_c;
         s1_row_ff    <= ROW_W'(cur_c);
         s1_col_ff    <= COL_W'(cur_x);
         s1_flags_ff  <= flags;
      end
   end

   assign rd1_addr  = cur_x;
   assign rd2_addr  = cur_x + XW'(r_ff);
   assign s1_valid  = s1_valid_ff;
   assign s1_pix    = s1_pix_ff;
   assign s1_x      = s1_x_ff;
   assign s1_slot_y = s1_slot_y_ff;
   assign s1_slot_c = s1_slot_c_ff;
   assign s1_row    = s1_row_ff;
   assign s1_col    = s1_col_ff;
   assign s1_flags  = s1_flags_ff;

endmodule

@@ rtl/core/cwba_window.sv @@
// Read-modify-write stage: merges the new pixel into its column word and ANDs the cross.
`timescale 1ns / 1ps

module cwba_window #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 3
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    acc,
   input  logic [$clog2(MAX_WIDTH)-1:0]            rd1_addr,
   input  logic                                    s1_valid,
   input  logic [cwba_pkg::PIX_W-1:0]              s1_pix,
   input  logic [$clog2(MAX_WIDTH)-1:0]            s1_x,
   input  logic [$clog2(2*MAX_RADIUS)-1:0]         s1_slot_y,
   input  logic [$clog2(2*MAX_RADIUS)-1:0]         s1_slot_c,
   input  logic [cwba_pkg::ROW_W-1:0]              s1_row,
   input  logic [cwba_pkg::COL_W-1:0]              s1_col,
   input  cwba_pkg::cwba_flags_type                s1_flags,
   input  logic [2*MAX_RADIUS*cwba_pkg::PIX_W-1:0] rd1_data,
   input  logic [2*MAX_RADIUS*cwba_pkg::PIX_W-1:0] rd2_data,
   output logic                                    wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]            wr_addr,
   output logic [2*MAX_RADIUS*cwba_pkg::PIX_W-1:0] wr_data,
   output logic                                    push,
   output cwba_pkg::cwba_rsp_type                  push_data
);
   import cwba_pkg::*;

   localparam int NSLOT  = 2 * MAX_RADIUS;
   localparam int WORD_W = NSLOT * PIX_W;

   logic              fwd_hit_ff;
   logic [WORD_W-1:0] fwd_word_ff;
   logic [PIX_W-1:0]  hl_ff [MAX_RADIUS];
   logic [PIX_W-1:0]  hr_ff [MAX_RADIUS];

   logic [WORD_W-1:0] word, merged;
   logic [PIX_W-1:0]  center_c, ahead_c, vert, left_arm, right_arm, value;

   always_comb begin
      int gap;
      gap = 0;
      // take the word just written back when the same column is read again at once
      word   = fwd_hit_ff ? fwd_word_ff : rd1_data;
      merged = word;
      merged[s1_slot_y*PIX_W +: PIX_W] = s1_pix;

      center_c = word[s1_slot_c*PIX_W +: PIX_W];
      ahead_c  = rd2_data[s1_slot_c*PIX_W +: PIX_W];

      // vertical arm: the 2r most recent rows at this column
      vert = s1_pix;
      for (int s = 0; s < NSLOT; s++) begin
         if (int'(s1_slot_y) > s) begin
            gap = int'(s1_slot_y) - s;
         end else begin
            gap = int'(s1_slot_y) + NSLOT - s;
         end
         if (gap <= 2 * int'(s1_flags.rad)) begin
            vert = vert & word[s*PIX_W +: PIX_W];
         end
      end

      left_arm = '1;
      for (int k = 0; k < MAX_RADIUS; k++) begin
         if (k < int'(s1_flags.rad)) begin
            left_arm = left_arm & hl_ff[k];
         end
      end

      right_arm = ahead_c;
      for (int k = 0; k < MAX_RADIUS; k++) begin
         if (k + 1 < int'(s1_flags.rad)) begin
            right_arm = right_arm & hr_ff[k];
         end
      end

      if (s1_flags.rad == '0) begin
         value = s1_pix;
      end else if (s1_flags.interior) begin
         value = vert & left_arm & right_arm;
      end else begin
         value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= s1_valid && acc && (rd1_addr == s1_x);
      end
   end

   // advance the horizontal lines of the centre row once per pixel
   always_ff @(posedge clock) begin
      fwd_word_ff <= merged;
      if (s1_valid) begin
         hl_ff[0] <= center_c;
         hr_ff[0] <= ahead_c;
         for (int k = 1; k < MAX_RADIUS; k++) begin
            hl_ff[k] <= hl_ff[k-1];
            hr_ff[k] <= hr_ff[k-1];
         end
      end
   end

   assign wr_en   = s1_valid;
   assign wr_addr = s1_x;
   assign wr_data = merged;

   assign push             = s1_valid && s1_flags.emit;
   assign push_data.done   = s1_flags.done;
   assign push_data.column = s1_col;
   assign push_data.row    = s1_row;
   assign push_data.value  = value;

endmodule

@@ rtl/core/cwba_ofifo.sv @@
// Small result queue that decouples the stage from the result channel.
`timescale 1ns / 1ps

module cwba_ofifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  cwba_pkg::cwba_rsp_type            push_data,
   output logic                              out_valid,
   input  logic                              out_ready,
   output cwba_pkg::cwba_rsp_type            out_data,
   output logic [cwba_pkg::FIFO_CW-1:0]      count
);
   import cwba_pkg::*;

   cwba_rsp_type         q_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 pop;

   assign pop = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = q_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

@@ rtl/core/cross_window_byte_and_core.sv @@
// Top level of the cross window AND core (plus-shaped erosion over a pixel stream).
//
//   channel  direction  payload
//   req_     in         tdata: pixel; tuser: frame_start
//   rsp_     out        tdata: value, row, column; tlast: frame_done
//   csr_     in         write enable, register index, write data
//
// One pixel per clock while req_tready is high. A result reaches the result queue after these steps:
// the column word read and the pixel are registered, then the merge, write-back and AND push it.
// The column store has one word per column; its single write port sets the rate.
// Reset is synchronous, restores the default settings and clears position and queue; the store is not cleared.
// req_tready drops only when the queued results plus the beat in flight fill the four-entry result queue.
`timescale 1ns / 1ps

module cross_window_byte_and_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_RADIUS = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] pixel
   input  logic                              req_tuser,   // [0] frame_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,   // [7:0] value, [19:8] row,
                                                          // [29:20] column, [31:30] zero
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [cwba_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [cwba_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cwba_pkg::*;

`include "cross_window_byte_and_core_defines.svh"

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int SW     = $clog2(2 * MAX_RADIUS);
   localparam int WORD_W = 2 * MAX_RADIUS * PIX_W;

   logic               acc;
   logic [XW-1:0]      rd1_addr, rd2_addr, s1_x, wr_addr;
   logic               s1_valid;
   logic [PIX_W-1:0]   s1_pix;
   logic [SW-1:0]      s1_slot_y, s1_slot_c;
   logic [ROW_W-1:0]   s1_row;
   logic [COL_W-1:0]   s1_col;
   cwba_flags_type     s1_flags;
   logic [WORD_W-1:0]  rd1_data, rd2_data, wr_data;
   logic               wr_en;
   logic               push;
   cwba_rsp_type       push_data, out_data;
   logic [FIFO_CW-1:0] fifo_count;

   assign req_tready = (32'(fifo_count) + 32'(s1_valid)) < FIFO_DEPTH;
   assign acc        = req_tvalid && req_tready;

   cwba_pos #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_pos (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .acc         (acc),
      .pixel       (req_tdata[PIX_W-1:0]),
      .frame_start (req_tuser),
      .rd1_addr    (rd1_addr),
      .rd2_addr    (rd2_addr),
      .s1_valid    (s1_valid),
      .s1_pix      (s1_pix),
      .s1_x        (s1_x),
      .s1_slot_y   (s1_slot_y),
      .s1_slot_c   (s1_slot_c),
      .s1_row      (s1_row),
      .s1_col      (s1_col),
      .s1_flags    (s1_flags)
   );

   cwba_store #(
      .DEPTH  (MAX_WIDTH),
      .WORD_W (WORD_W)
   ) u_store (
      .clock    (clock),
      .rd_en    (acc),
      .rd1_addr (rd1_addr),
      .rd2_addr (rd2_addr),
      .rd1_data (rd1_data),
      .rd2_data (rd2_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   cwba_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .acc       (acc),
      .rd1_addr  (rd1_addr),
      .s1_valid  (s1_valid),
      .s1_pix    (s1_pix),
      .s1_x      (s1_x),
      .s1_slot_y (s1_slot_y),
      .s1_slot_c (s1_slot_c),
      .s1_row    (s1_row),
      .s1_col    (s1_col),
      .s1_flags  (s1_flags),
      .rd1_data  (rd1_data),
      .rd2_data  (rd2_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .push      (push),
      .push_data (push_data)
   );

   cwba_ofifo u_ofifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data),
      .count     (fifo_count)
   );

   assign rsp_tdata = {2'b00, out_data.column, out_data.row, out_data.value};
   assign rsp_tlast = out_data.done;

   `CWBA_ASSERT_NOW(a_no_overflow, push, (32'(fifo_count) < FIFO_DEPTH), "result queue overflow")
   `CWBA_ASSERT_NOW(a_full_stalls, (32'(fifo_count) == FIFO_DEPTH), !req_tready, "ready when full")
   `CWBA_ASSERT_NEXT(a_beat_advances, acc, s1_valid, "accepted beat did not reach the merge stage")
   `CWBA_ASSERT_NOW(a_write_follows, s1_valid, (wr_en && (wr_addr == s1_x)), "no write-back")

endmodule

@@ dv/tb_cross_window_byte_and_core.sv @@
// Self-checking testbench for the cross window AND core: directed table, then random frames.
`timescale 1ns / 1ps

module tb_cross_window_byte_and_core;
   import cwba_pkg::*;

   localparam int MAX_W         = 1024;
   localparam int MAX_H         = 4096;
   localparam int MAX_R         = 3;
   localparam int STORE_ROWS    = 2 * MAX_R;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_CYCLES  = 300;
   localparam int RANDOM_ITEMS  = 200;
   localparam int CYCLE_LIMIT   = 400000;

   // Index past the register list: changes nothing but the position.
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {ROW_CSR, ROW_PIX, ROW_PIX_TYPED} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] wdata;
      logic [PIX_W-1:0]      pixel;
      logic                  fs;
      cwba_rsp_type          typed_res;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [31:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predictor state
   logic [FW_W-1:0]  width_reg  = FW_W'(RESET_WIDTH);
   logic [FH_W-1:0]  height_reg = FH_W'(RESET_HEIGHT);
   logic [RAD_W-1:0] radius_reg = RAD_W'(RESET_RADIUS);
   logic [PIX_W-1:0] line_store [0:STORE_ROWS*MAX_W-1];
   int               row_pos = 0;
   int               col_pos = 0;

   cwba_rsp_type eroded_q[$];
   plan_row_type plan[$];
   int           fail_count    = 0;
   int           pixels_sent   = 0;
   int           cycle_count   = 0;
   int           send_idle_pct = 15;
   int           recv_idle_pct = 53;
   bit           stall_req     = 1'b0;

   cross_window_byte_and_core #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H),
      .MAX_RADIUS (MAX_R)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] pixel
      .req_tuser  (req_tuser),    // [0] frame_start
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] value, [19:8] row, [29:20] column, [31:30] zero
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return int'(width_reg);
   endfunction

   function automatic int eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return int'(height_reg);
   endfunction

   function automatic logic [PIX_W-1:0] stored(int r, int c);
      return line_store[(r % STORE_ROWS) * MAX_W + c];
   endfunction

   // Mostly near-white bytes, so the AND over the cross does not collapse to zero.
   function automatic logic [PIX_W-1:0] pixel_value();
      case ($urandom_range(3))
         0: begin
            return 8'($urandom_range(255));
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return ~(8'h01 << $urandom_range(7));
         end
      endcase
   endfunction

   task automatic erode_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                              output logic emits, output cwba_rsp_type res);
      int               w;
      int               h;
      int               r;
      int               y;
      int               x;
      int               c;
      logic [PIX_W-1:0] v;
      w = eff_w();
      h = eff_h();
      r = (radius_reg > MAX_R) ? MAX_R : int'(radius_reg);
      emits = 1'b0;
      res = '0;
      if (fs) begin
         row_pos = 0;
         col_pos = 0;
      end
      if (row_pos >= h) row_pos = 0;
      if (col_pos >= w) col_pos = 0;
      y = row_pos;
      x = col_pos;
      if (y >= r) begin
         c = y - r;
         if (r == 0) begin
            v = pix;
         end else if (c >= r && x >= r && x + r < w) begin
            v = pix & stored(c, x);
            for (int k = 1; k <= r; k++) begin
               v &= stored(c, x - k) & stored(c, x + k) & stored(c - k, x);
               // row c + r is the arriving pixel itself
               if (k < r) v &= stored(c + k, x);
            end
         end else begin
            v = '0;
         end
         res.value  = v;
         res.row    = c[ROW_W-1:0];
         res.column = x[COL_W-1:0];
         res.done   = (y == h - 1) && (x == w - 1);
         emits = 1'b1;
      end
      line_store[(y % STORE_ROWS) * MAX_W + x] = pix;
      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end
      row_pos = y;
      col_pos = x;
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                             input logic typed, input cwba_rsp_type typed_res);
      logic         emits;
      cwba_rsp_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= fs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      erode_pixel(pix, fs, emits, res);
      if (typed) eroded_q.push_back(typed_res);
      else if (emits) eroded_q.push_back(res);
      pixels_sent++;
   endtask

   task automatic send_frame(input int count, input logic fs_first);
      for (int i = 0; i < count; i++) begin
         send_pixel(pixel_value(), (i == 0) ? fs_first : 1'b0, 1'b0, '0);
      end
   endtask

   // Hold the sender until every result is back, then let the pipeline empty.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (eroded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (addr)
         CSR_FRAME_WIDTH: begin
            width_reg = data[FW_W-1:0];
         end
         CSR_FRAME_HEIGHT: begin
            height_reg = data[FH_W-1:0];
         end
         CSR_RADIUS: begin
            radius_reg = data[RAD_W-1:0];
         end
         default: begin
         end
      endcase
      row_pos = 0;
      col_pos = 0;
   endtask

   task automatic add_row(input row_kind_type kind, input logic [CSR_ADDR_W-1:0] addr,
                          input logic [CSR_DATA_W-1:0] wdata, input logic [PIX_W-1:0] pixel,
                          input logic fs, input logic [PIX_W-1:0] value,
                          input logic [ROW_W-1:0] row, input logic [COL_W-1:0] column,
                          input logic done);
      plan_row_type p;
      p.kind             = kind;
      p.addr             = addr;
      p.wdata            = wdata;
      p.pixel            = pixel;
      p.fs               = fs;
      p.typed_res.value  = value;
      p.typed_res.row    = row;
      p.typed_res.column = column;
      p.typed_res.done   = done;
      plan.push_back(p);
   endtask

   // Receiver: random back-pressure, plus a long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_req) begin
            stall_req  = 1'b0;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cwba_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (eroded_q.size() == 0) begin
            $error("unexpected beat: value %0h row %0d column %0d last %0b",
                   rsp_tdata[7:0], rsp_tdata[19:8], rsp_tdata[29:20], rsp_tlast);
            fail_count++;
         end else begin
            want = eroded_q.pop_front();
            if (rsp_tdata[7:0] !== want.value) begin
               $error("value: expected %0h, actual %0h", want.value, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[19:8] !== want.row) begin
               $error("row: expected %0d, actual %0d", want.row, rsp_tdata[19:8]);
               fail_count++;
            end
            if (rsp_tdata[29:20] !== want.column) begin
               $error("column: expected %0d, actual %0d", want.column, rsp_tdata[29:20]);
               fail_count++;
            end
            if (rsp_tdata[31:30] !== 2'b00) begin
               $error("pad: expected 0, actual %0h", rsp_tdata[31:30]);
               fail_count++;
            end
            if (rsp_tlast !== want.done) begin
               $error("frame_done: expected %0b, actual %0b", want.done, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int   choice;
      int   span;
      int   phase_end;
      logic fresh;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      for (int i = 0; i < STORE_ROWS * MAX_W; i++) line_store[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings first: the top row gives nothing at radius one.
      add_row(ROW_PIX,       '0,               '0,       8'h12, 1'b1, 8'h00, 0, 0, 1'b0);
      // Radius zero on a one-pixel frame: every pixel is its own last result.
      add_row(ROW_CSR,       CSR_RADIUS,       13'd0,    8'h00, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_CSR,       CSR_FRAME_WIDTH,  13'd0,    8'h00, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_CSR,       CSR_FRAME_HEIGHT, 13'd0,    8'h00, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX_TYPED, '0,               '0,       8'h00, 1'b1, 8'h00, 0, 0, 1'b1);
      add_row(ROW_PIX_TYPED, '0,               '0,       8'hFF, 1'b0, 8'hFF, 0, 0, 1'b1);
      add_row(ROW_PIX_TYPED, '0,               '0,       8'hA5, 1'b1, 8'hA5, 0, 0, 1'b1);
      // Oversized settings clamp to the maximum frame.
      add_row(ROW_CSR,       CSR_FRAME_WIDTH,  13'd2047, 8'h00, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_CSR,       CSR_FRAME_HEIGHT, 13'd8191, 8'h00, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX_TYPED, '0,               '0,       8'h5A, 1'b1, 8'h5A, 0, 0, 1'b0);
      add_row(ROW_PIX_TYPED, '0,               '0,       8'h3C, 1'b0, 8'h3C, 0, 1, 1'b0);
      // A write to the spare index only rewinds the position.
      add_row(ROW_CSR,       CSR_UNUSED,       13'h1FFF, 8'h00, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX_TYPED, '0,               '0,       8'h81, 1'b0, 8'h81, 0, 0, 1'b0);
      // 3x3 frame at radius one: only the middle centre is interior.
      add_row(ROW_CSR,       CSR_RADIUS,       13'd1,    8'h00, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_CSR,       CSR_FRAME_WIDTH,  13'd3,    8'h00, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_CSR,       CSR_FRAME_HEIGHT, 13'd3,    8'h00, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX,       '0,               '0,       8'hFF, 1'b1, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX,       '0,               '0,       8'hF7, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX,       '0,               '0,       8'hFF, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX_TYPED, '0,               '0,       8'hFE, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX_TYPED, '0,               '0,       8'h7F, 1'b0, 8'h00, 0, 1, 1'b0);
      add_row(ROW_PIX_TYPED, '0,               '0,       8'hEF, 1'b0, 8'h00, 0, 2, 1'b0);
      add_row(ROW_PIX_TYPED, '0,               '0,       8'hDF, 1'b0, 8'h00, 1, 0, 1'b0);
      add_row(ROW_PIX,       '0,               '0,       8'hFB, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX_TYPED, '0,               '0,       8'hBF, 1'b0, 8'h00, 1, 2, 1'b1);
      // Frame shorter than the radius: nothing comes out.
      add_row(ROW_CSR,       CSR_RADIUS,       13'd3,    8'h00, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_CSR,       CSR_FRAME_WIDTH,  13'd2,    8'h00, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_CSR,       CSR_FRAME_HEIGHT, 13'd2,    8'h00, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX,       '0,               '0,       8'h55, 1'b1, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX,       '0,               '0,       8'hAA, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX,       '0,               '0,       8'h0F, 1'b0, 8'h00, 0, 0, 1'b0);
      add_row(ROW_PIX,       '0,               '0,       8'hF0, 1'b0, 8'h00, 0, 0, 1'b0);

      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_CSR: begin
               write_reg(plan[i].addr, plan[i].wdata);
            end
            ROW_PIX: begin
               send_pixel(plan[i].pixel, plan[i].fs, 1'b0, '0);
            end
            default: begin
               send_pixel(plan[i].pixel, plan[i].fs, 1'b1, plan[i].typed_res);
            end
         endcase
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 53 : 0;
         recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 15 : 0;
         phase_end = pixels_sent + RANDOM_ITEMS;

         // Long receiver hold-off while a full frame is offered: fill the queue.
         write_reg(CSR_FRAME_WIDTH, 13'd16);
         write_reg(CSR_FRAME_HEIGHT, 13'd8);
         write_reg(CSR_RADIUS, 13'd1);
         stall_req = 1'b1;
         send_frame(128, 1'b1);

         while (pixels_sent < phase_end) begin
            choice = $urandom_range(99);
            if (choice < 70) begin
               // well-formed frames, often under a fresh setting
               fresh = (eff_h() > 12 || eff_w() > 16 || $urandom_range(2) == 0);
               if (fresh) begin
                  write_reg(CSR_FRAME_WIDTH, 13'($urandom_range(0, 16)));
                  write_reg(CSR_FRAME_HEIGHT, 13'($urandom_range(0, 12)));
                  write_reg(CSR_RADIUS, 13'($urandom_range(0, 3)));
               end
               send_frame(eff_w() * eff_h() * $urandom_range(1, 2),
                          fresh ? 1'($urandom_range(1)) : 1'b1);
            end else if (choice < 85) begin
               // cut a frame short; the next frame start lands mid-frame
               span = eff_w() * eff_h();
               send_frame($urandom_range(1, (span < 64) ? span : 64), 1'b1);
            end else if (choice < 92) begin
               write_reg(CSR_FRAME_HEIGHT, 13'($urandom_range(4097, 8191)));
               send_frame(eff_w() * $urandom_range(1, 6), 1'b1);
            end else if (choice < 96) begin
               write_reg(CSR_UNUSED, 13'($urandom_range(0, 8191)));
            end else begin
               repeat ($urandom_range(1, 8)) begin
                  send_pixel(pixel_value(), 1'($urandom_range(1)), 1'b0, '0);
               end
            end
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/cwba_pkg.sv
rtl/core/cwba_store.sv
rtl/core/cwba_pos.sv
rtl/core/cwba_window.sv
rtl/core/cwba_ofifo.sv
rtl/core/cross_window_byte_and_core.sv
dv/tb_cross_window_byte_and_core.sv
